FILE: design/tms_pkg.sv
// Shared types and constants of the transform matrix stack.
package tms_pkg;

    localparam int ELEM_W = 32;
    localparam int ACC_W  = 66;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [2:0] {
        OP_REPLACE  = 3'd0,
        OP_PUSH     = 3'd1,
        OP_MULTIPLY = 3'd2,
        OP_POP      = 3'd3,
        OP_RESET    = 3'd4,
        OP_READ     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POP_BOTTOM = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_MUL,
        S_DRAIN,
        S_WB,
        S_RD_ADDR,
        S_RD_DATA,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    load_elem;
        logic    copy_wr;
        logic    push;
        logic    mul_issue;
        logic    wb_wr;
        logic    cnt_inc;
        logic    cnt_clr;
        logic    depth_inc;
        logic    depth_dec;
        logic    depth_reset;
        logic    out_load_read;
        logic    out_load_single;
        t_status status;
        logic    changed;
    } t_cmd;

    typedef struct packed {
        logic cnt16_last;
        logic cnt64_last;
        logic pipe_busy;
        logic full;
        logic bottom;
        logic out_valid;
    } t_stat;

endpackage

FILE: design/tms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: design/tms_ctrl.sv
// Controller state machine of the transform matrix stack.
module tms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [2:0]     i_operation,
    input  logic [3:0]     i_element_index,
    input  logic           i_out_ready,
    input  tms_pkg::t_stat i_stat,
    output logic           o_ready,
    output tms_pkg::t_cmd  o_cmd
);
    import tms_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_changed, n_changed;
    logic    r_push, n_push;
    logic    accept;
    logic    run;
    logic    out_free;
    t_op     op;

    assign o_ready  = (r_state == S_IDLE) && (!i_stat.out_valid || i_element_index != 4'd15);
    assign accept   = i_valid && o_ready;
    assign run      = accept && i_element_index == 4'd15;
    assign out_free = !i_stat.out_valid || i_out_ready;
    assign op       = t_op'(i_operation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= ST_DONE;
            r_changed <= 1'b0;
            r_push    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_changed <= n_changed;
            r_push    <= n_push;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_changed = r_changed;
        n_push    = r_push;
        unique case (r_state)
            S_IDLE: begin
                if (run) begin
                    n_status  = ST_DONE;
                    n_changed = 1'b0;
                    n_push    = 1'b0;
                    unique case (op)
                        OP_REPLACE: n_state = S_COPY;
                        OP_PUSH: begin
                            if (i_stat.full) begin
                                n_status = ST_PUSH_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_push  = 1'b1;
                                n_state = S_COPY;
                            end
                        end
                        OP_MULTIPLY: n_state = S_MUL;
                        OP_POP: begin
                            if (i_stat.bottom) begin
                                n_status = ST_POP_BOTTOM;
                            end else begin
                                n_changed = 1'b1;
                            end
                            n_state = S_RESP;
                        end
                        OP_RESET: begin
                            n_changed = 1'b1;
                            n_state   = S_RESP;
                        end
                        OP_READ: n_state = S_RD_ADDR;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_COPY: begin
                if (i_stat.cnt16_last) begin
                    n_changed = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_MUL: begin
                if (i_stat.cnt64_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (i_stat.cnt16_last) begin
                    n_changed = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_RD_ADDR: n_state = S_RD_DATA;
            S_RD_DATA: begin
                if (out_free) begin
                    n_state = i_stat.cnt16_last ? S_IDLE : S_RD_ADDR;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.push    = r_push;
        o_cmd.status  = r_status;
        o_cmd.changed = r_changed;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_elem = accept;
                if (run && op == OP_POP && !i_stat.bottom) begin
                    o_cmd.depth_dec = 1'b1;
                end
                if (run && op == OP_RESET) begin
                    o_cmd.depth_reset = 1'b1;
                end
            end
            S_COPY: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt16_last) begin
                    o_cmd.cnt_clr   = 1'b1;
                    o_cmd.depth_inc = r_push;
                end
            end
            S_MUL: begin
                o_cmd.mul_issue = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
            end
            S_DRAIN: o_cmd.cnt_clr = 1'b1;
            S_WB: begin
                o_cmd.wb_wr   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.cnt_clr = i_stat.cnt16_last;
            end
            S_RD_ADDR: ;
            S_RD_DATA: begin
                if (out_free) begin
                    o_cmd.out_load_read = 1'b1;
                    o_cmd.cnt_inc       = 1'b1;
                    o_cmd.cnt_clr       = i_stat.cnt16_last;
                end
            end
            S_RESP: o_cmd.out_load_single = out_free;
            default: ;
        endcase
    end
endmodule

FILE: design/tms_dp.sv
// Datapath: operand buffer, matrix memory, multiply-accumulate and output word.
module tms_dp #(
    parameter int STACK_DEPTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tms_pkg::t_cmd         i_cmd,
    input  logic [3:0]            i_element_index,
    input  logic signed [31:0]    i_element_value,
    input  logic                  i_out_ready,
    output tms_pkg::t_stat        o_stat,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic                  o_changed,
    output logic [4:0]            o_stack_depth,
    output logic signed [31:0]    o_top_value,
    output logic [3:0]            o_top_index,
    output logic                  o_last
);
    import tms_pkg::*;

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int AW = SW + 4;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(1) << FRACTION_BITS;

    logic signed [ELEM_W-1:0] r_opbuf  [16];
    logic signed [ELEM_W-1:0] r_resbuf [16];
    logic [DW-1:0]            r_depth;
    logic                     r_ident;
    logic [5:0]               r_cnt;
    logic                     r_ov_sel;
    logic                     r_ov_diag;

    logic                     r_a_v, r_a_first, r_a_lastk;
    logic [3:0]               r_a_el;
    logic signed [ELEM_W-1:0] r_a_op;
    logic                     r_b_v, r_b_first, r_b_lastk;
    logic [3:0]               r_b_el;
    logic signed [63:0]       r_b_p;
    logic                     r_c_v;
    logic [3:0]               r_c_el;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic                     r_out_changed;
    logic [4:0]               r_out_depth;
    logic signed [ELEM_W-1:0] r_out_value;
    logic [3:0]               r_out_index;
    logic                     r_out_last;

    logic [SW-1:0]            top_blk, push_blk, wr_blk;
    logic [3:0]               rd_low;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic                     wr_en;
    logic [ELEM_W-1:0]        wr_data;
    logic [ELEM_W-1:0]        ram_data;
    logic signed [ELEM_W-1:0] top_data;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [ELEM_W-1:0] sat_val;

    assign top_blk  = SW'(r_depth - DW'(1));
    assign push_blk = SW'(r_depth);
    assign wr_blk   = i_cmd.push ? push_blk : top_blk;
    assign rd_low   = i_cmd.mul_issue ? {r_cnt[1:0], r_cnt[3:2]} : r_cnt[3:0];
    assign rd_addr  = {top_blk, rd_low};
    assign wr_addr  = {wr_blk, r_cnt[3:0]};
    assign wr_en    = i_cmd.copy_wr || i_cmd.wb_wr;
    assign wr_data  = i_cmd.copy_wr ? r_opbuf[r_cnt[3:0]] : r_resbuf[r_cnt[3:0]];

    tms_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STACK_DEPTH * 16)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_data)
    );

    assign top_data = r_ov_sel ? (r_ov_diag ? ONE : '0) : $signed(ram_data);

    assign shifted = r_acc >>> FRACTION_BITS;
    always_comb begin
        priority if (shifted > SAT_MAX) begin
            sat_val = SAT_MAX[ELEM_W-1:0];
        end else if (shifted < SAT_MIN) begin
            sat_val = SAT_MIN[ELEM_W-1:0];
        end else begin
            sat_val = shifted[ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_elem) begin
            r_opbuf[i_element_index] <= i_element_value;
        end
        r_ov_sel  <= r_ident && (top_blk == '0);
        r_ov_diag <= rd_low[1:0] == rd_low[3:2];
        r_a_op    <= r_opbuf[{r_cnt[5:4], r_cnt[1:0]}];
        r_a_first <= r_cnt[1:0] == 2'd0;
        r_a_lastk <= r_cnt[1:0] == 2'd3;
        r_a_el    <= {r_cnt[5:4], r_cnt[3:2]};
        r_b_p     <= top_data * r_a_op;
        r_b_first <= r_a_first;
        r_b_lastk <= r_a_lastk;
        r_b_el    <= r_a_el;
        if (r_b_v) begin
            r_acc <= r_b_first ? ACC_W'(r_b_p) + HALF : r_acc + ACC_W'(r_b_p);
        end
        r_c_el <= r_b_el;
        if (r_c_v) begin
            r_resbuf[r_c_el] <= sat_val;
        end
        if (i_cmd.out_load_read) begin
            r_out_status  <= ST_DONE;
            r_out_changed <= 1'b0;
            r_out_depth   <= 5'(r_depth);
            r_out_value   <= top_data;
            r_out_index   <= r_cnt[3:0];
            r_out_last    <= r_cnt[3:0] == 4'd15;
        end else if (i_cmd.out_load_single) begin
            r_out_status  <= i_cmd.status;
            r_out_changed <= i_cmd.changed;
            r_out_depth   <= 5'(r_depth);
            r_out_value   <= '0;
            r_out_index   <= '0;
            r_out_last    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DW'(1);
            r_ident     <= 1'b1;
            r_cnt       <= '0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_cmd.depth_reset) begin
                r_depth <= DW'(1);
            end else if (i_cmd.depth_inc) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_cmd.depth_dec) begin
                r_depth <= r_depth - DW'(1);
            end
            priority if (i_cmd.depth_reset) begin
                r_ident <= 1'b1;
            end else if (wr_en && wr_blk == '0) begin
                r_ident <= 1'b0;
            end
            priority if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 6'd1;
            end
            r_a_v <= i_cmd.mul_issue;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v && r_b_lastk;
            priority if (i_cmd.out_load_read || i_cmd.out_load_single) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.cnt16_last = r_cnt[3:0] == 4'd15;
    assign o_stat.cnt64_last = r_cnt == 6'd63;
    assign o_stat.pipe_busy  = r_a_v || r_b_v || r_c_v;
    assign o_stat.full       = r_depth >= DW'(STACK_DEPTH);
    assign o_stat.bottom     = r_depth <= DW'(1);
    assign o_stat.out_valid  = r_out_valid;

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_changed     = r_out_changed;
    assign o_stack_depth = r_out_depth;
    assign o_top_value   = r_out_value;
    assign o_top_index   = r_out_index;
    assign o_last        = r_out_last;
endmodule

FILE: design/transform_matrix_stack.sv
// Top level of the transform matrix stack.
//
//  channel | valid / ready      | word
//  --------+--------------------+-----------------------------------------------
//  input   | i_valid / o_ready  | i_operation, i_element_index, i_element_value
//  output  | o_valid / i_ready  | o_status, o_changed, o_stack_depth,
//          |                    | o_top_value, o_top_index, o_last
//
// Elements 0 to 14 are buffered; element 15 starts the operation: replace
// or push copies 16 words to memory, pop and reset respond directly, read
// sends 16 words, each via an address and a data state, multiply issues 64
// products on the one multiply-accumulate unit, drains, writes 16 memory
// words and responds. Synchronous active-low reset leaves an identity at the
// bottom; no clearing pass. A held output word stalls an element 15 word and the remaining words of a read.
module transform_matrix_stack #(
    parameter int STACK_DEPTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_operation,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic               o_changed,
    output logic [4:0]         o_stack_depth,
    output logic signed [31:0] o_top_value,
    output logic [3:0]         o_top_index,
    output logic               o_last
);
    import tms_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tms_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_operation     (i_operation),
        .i_element_index (i_element_index),
        .i_out_ready     (i_ready),
        .i_stat          (stat),
        .o_ready         (o_ready),
        .o_cmd           (cmd)
    );

    tms_dp #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_out_ready     (i_ready),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_changed       (o_changed),
        .o_stack_depth   (o_stack_depth),
        .o_top_value     (o_top_value),
        .o_top_index     (o_top_index),
        .o_last          (o_last)
    );
endmodule
